FILE: sv/dtm_pkg.sv
`timescale 1ns / 1ps

package dtm_pkg;

    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;
    localparam int STORE_SIZE   = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int ADDR_W       = $clog2(STORE_SIZE);

    localparam int X_W        = 10;
    localparam int Y_W        = 9;
    localparam int DEPTH_W    = 16;
    localparam int LEVEL_W    = 8;
    localparam int GAIN_W     = 24;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int S_W        = 17;   // Q16 scaled difference, up to 1.0
    localparam int SQ_W       = 33;   // Q32, up to 2^32
    localparam int CUBE_W     = 49;   // Q48, up to 2^48

    localparam logic [S_W-1:0]     ONE_Q16   = S_W'(65536);
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = LEVEL_W'(255);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DEPTH_GAIN   = 3'd0,
        REG_WINDOW_X_MIN = 3'd1,
        REG_WINDOW_X_MAX = 3'd2,
        REG_WINDOW_Y_MIN = 3'd3,
        REG_WINDOW_Y_MAX = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [Y_W-1:0] y;
        logic [X_W-1:0] x;
    } coord_t;

    // Pixel as it leaves the store-read stage.
    typedef struct packed {
        logic               vld;
        logic               live;
        coord_t             coord;
        logic [DEPTH_W-1:0] depth;
    } st2_t;

    typedef struct packed {
        coord_t             coord;
        logic [LEVEL_W-1:0] level;
    } res_t;

endpackage

FILE: sv/dtm_frame_store.sv
`timescale 1ns / 1ps

module dtm_frame_store (
    input  logic                          clk,
    input  logic                          en,
    input  logic                          wr_en,
    input  logic [dtm_pkg::ADDR_W-1:0]    addr,
    input  logic [dtm_pkg::DEPTH_W-1:0]   wr_data,
    output logic [dtm_pkg::DEPTH_W-1:0]   rd_data
);
    import dtm_pkg::*;

    logic [DEPTH_W-1:0] mem [STORE_SIZE];
    logic [DEPTH_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
    end

    // Read-first: a pixel written here in this cycle is never compared
    // against this read, so the old contents are what a later pixel needs.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/dtm_level_pipe.sv
`timescale 1ns / 1ps

module dtm_level_pipe (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  dtm_pkg::st2_t                st2,
    input  logic [dtm_pkg::DEPTH_W-1:0]  bg,
    input  logic [dtm_pkg::GAIN_W-1:0]   gain,
    output logic                         res_vld,
    output dtm_pkg::res_t                res
);
    import dtm_pkg::*;

    logic               st3_vld_reg, st4_vld_reg, st5_vld_reg, st6_vld_reg, st7_vld_reg;
    coord_t             st3_coord_reg, st4_coord_reg, st5_coord_reg, st6_coord_reg;
    coord_t             st7_coord_reg;
    logic [DEPTH_W-1:0] st3_diff_reg, st3_diff_next;
    logic [S_W-1:0]     st4_s_reg, st4_s_next;
    logic [S_W-1:0]     st5_s_reg;
    logic [SQ_W-1:0]    st5_sq_reg, st5_sq_next;
    logic [CUBE_W-1:0]  st6_cube_reg, st6_cube_next;
    logic [LEVEL_W-1:0] st7_level_reg, st7_level_next;

    logic [DEPTH_W+GAIN_W-1:0] prod;
    logic [GAIN_W-1:0]         prod_q16;
    logic [CUBE_W+7:0]         scaled;
    logic [8:0]                lvl_wide;

    always_comb
    begin
        if (st2.live && (bg > st2.depth))
        begin
            st3_diff_next = bg - st2.depth;
        end
        else
        begin
            st3_diff_next = '0;
        end
    end

    always_comb
    begin
        prod     = (DEPTH_W+GAIN_W)'(st3_diff_reg) * (DEPTH_W+GAIN_W)'(gain);
        prod_q16 = prod[DEPTH_W+GAIN_W-1:16];
        if (prod_q16 > GAIN_W'(ONE_Q16))
        begin
            st4_s_next = ONE_Q16;
        end
        else
        begin
            st4_s_next = prod_q16[S_W-1:0];
        end
    end

    assign st5_sq_next   = SQ_W'(st4_s_reg) * SQ_W'(st4_s_reg);
    assign st6_cube_next = CUBE_W'(st5_sq_reg) * CUBE_W'(st5_s_reg);

    // Times 255 is times 256 less one; the cube never exceeds 2^48.
    always_comb
    begin
        scaled   = {st6_cube_reg, 8'd0} - (CUBE_W+8)'(st6_cube_reg);
        lvl_wide = scaled[CUBE_W+7:48];
        if (lvl_wide > 9'(LEVEL_MAX))
        begin
            st7_level_next = LEVEL_MAX;
        end
        else
        begin
            st7_level_next = lvl_wide[LEVEL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st3_vld_reg <= 1'b0;
            st4_vld_reg <= 1'b0;
            st5_vld_reg <= 1'b0;
            st6_vld_reg <= 1'b0;
            st7_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            st3_vld_reg <= st2.vld;
            st4_vld_reg <= st3_vld_reg;
            st5_vld_reg <= st4_vld_reg;
            st6_vld_reg <= st5_vld_reg;
            st7_vld_reg <= st6_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st3_coord_reg <= st2.coord;
            st3_diff_reg  <= st3_diff_next;
            st4_coord_reg <= st3_coord_reg;
            st4_s_reg     <= st4_s_next;
            st5_coord_reg <= st4_coord_reg;
            st5_s_reg     <= st4_s_reg;
            st5_sq_reg    <= st5_sq_next;
            st6_coord_reg <= st5_coord_reg;
            st6_cube_reg  <= st6_cube_next;
            st7_coord_reg <= st6_coord_reg;
            st7_level_reg <= st7_level_next;
        end
    end

    assign res_vld   = st7_vld_reg;
    assign res.coord = st7_coord_reg;
    assign res.level = st7_level_reg;

`ifndef SYNTHESIS
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        st4_vld_reg |-> (st4_s_reg <= ONE_Q16))
        else $error("scaled difference above 1.0");

    a_cube_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (st6_vld_reg && st6_cube_reg[CUBE_W-1]) |-> (st6_cube_reg[CUBE_W-2:0] == '0))
        else $error("cube above 2^48");
`endif

endmodule

FILE: sv/dtm_out_skid.sv
`timescale 1ns / 1ps

module dtm_out_skid (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_vld,
    input  dtm_pkg::res_t res,
    output logic          pipe_en,
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [31:0]   m_tdata     // out_x[9:0], out_y[18:10], touch_level[26:19]
);
    import dtm_pkg::*;

    logic out_vld_reg, out_vld_next;
    logic skid_vld_reg, skid_vld_next;
    res_t out_reg, out_next;
    res_t skid_reg, skid_next;

    assign pipe_en = !skid_vld_reg;

    always_comb
    begin
        out_vld_next  = out_vld_reg;
        out_next      = out_reg;
        skid_vld_next = skid_vld_reg;
        skid_next     = skid_reg;
        priority if (skid_vld_reg)
        begin
            if (m_tready)
            begin
                out_next      = skid_reg;
                skid_vld_next = 1'b0;
            end
        end
        else if (res_vld)
        begin
            if (!out_vld_reg || m_tready)
            begin
                out_vld_next = 1'b1;
                out_next     = res;
            end
            else
            begin
                skid_vld_next = 1'b1;
                skid_next     = res;
            end
        end
        else if (m_tready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {5'd0, out_reg.level, out_reg.coord.y, out_reg.coord.x};

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_vld_reg |-> out_vld_reg)
        else $error("skid stage holds a transfer while the output is empty");
`endif

endmodule

FILE: sv/depth_touch_map.sv
`timescale 1ns / 1ps
// A pixel accepted from the input passes stages st1 to st7 and the output register before it
// appears on m_tvalid. One pixel per cycle while the output skid entry is empty; the frame
// store is read once and written at most once per pixel.
// A two-entry output stage keeps s_tready high while one result waits to be taken.
// Reset (rst_n, asynchronous, active low) clears the pipeline and the background-taken
// flag and loads the register defaults; the frame store is not cleared.
module depth_touch_map (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [39:0]                     s_tdata,   // pixel_x[9:0], pixel_y[18:10], depth[34:19]
    input  logic                            s_tuser,   // mode
    input  logic                            s_tlast,   // frame_end
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,   // out_x[9:0], out_y[18:10], touch_level[26:19]
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dtm_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dtm_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import dtm_pkg::*;

    logic               pipe_en;
    logic               accept;
    logic [X_W-1:0]     pixel_x;
    logic [Y_W-1:0]     pixel_y;
    logic [DEPTH_W-1:0] depth;
    logic               in_frame, in_window, store;

    logic [GAIN_W-1:0]  depth_gain_reg;
    logic [X_W-1:0]     x_min_reg, x_max_reg;
    logic [Y_W-1:0]     y_min_reg, y_max_reg;
    logic               bg_valid_reg;

    logic               st1_vld_reg, st1_live_reg, st1_wr_reg;
    logic [ADDR_W-1:0]  st1_addr_reg;
    coord_t             st1_coord_reg;
    logic [DEPTH_W-1:0] st1_depth_reg;
    logic               st2_vld_reg, st2_live_reg;
    coord_t             st2_coord_reg;
    logic [DEPTH_W-1:0] st2_depth_reg;
    st2_t               st2;
    logic [DEPTH_W-1:0] bg_rd;
    logic               res_vld;
    res_t               res;

    assign pixel_x = s_tdata[9:0];
    assign pixel_y = s_tdata[18:10];
    assign depth   = s_tdata[34:19];

    assign s_tready  = pipe_en;
    assign accept    = s_tvalid && pipe_en;
    assign cfg_ready = 1'b1;

    assign in_frame  = (32'(pixel_x) < FRAME_WIDTH) && (32'(pixel_y) < FRAME_HEIGHT);
    assign in_window = (pixel_x >= x_min_reg) && (pixel_x <= x_max_reg) &&
                       (pixel_y >= y_min_reg) && (pixel_y <= y_max_reg);
    assign store     = s_tuser || !bg_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_gain_reg <= GAIN_W'(65536);
            x_min_reg      <= '0;
            x_max_reg      <= '0;
            y_min_reg      <= '0;
            y_max_reg      <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_DEPTH_GAIN:   depth_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_WINDOW_X_MIN: x_min_reg      <= cfg_data[X_W-1:0];
                REG_WINDOW_X_MAX: x_max_reg      <= cfg_data[X_W-1:0];
                REG_WINDOW_Y_MIN: y_min_reg      <= cfg_data[Y_W-1:0];
                REG_WINDOW_Y_MAX: y_max_reg      <= cfg_data[Y_W-1:0];
                default: ;
            endcase
        end
    end

    // Every in-frame pixel of the first frame is taken as background.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bg_valid_reg <= 1'b0;
        end
        else if (accept && s_tlast)
        begin
            bg_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st1_vld_reg <= 1'b0;
            st2_vld_reg <= 1'b0;
        end
        else if (pipe_en)
        begin
            st1_vld_reg <= s_tvalid;
            st2_vld_reg <= st1_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            st1_wr_reg    <= in_frame && store;
            // A pixel stored now is not scored; its level comes out as zero.
            st1_live_reg  <= in_frame && in_window && !store && (depth != '0);
            st1_addr_reg  <= ADDR_W'(pixel_y) * ADDR_W'(FRAME_WIDTH) + ADDR_W'(pixel_x);
            st1_coord_reg <= '{y: pixel_y, x: pixel_x};
            st1_depth_reg <= depth;
            st2_live_reg  <= st1_live_reg;
            st2_coord_reg <= st1_coord_reg;
            st2_depth_reg <= st1_depth_reg;
        end
    end

    assign st2 = '{vld: st2_vld_reg, live: st2_live_reg, coord: st2_coord_reg,
                   depth: st2_depth_reg};

    dtm_frame_store u_store (
        .clk     (clk),
        .en      (pipe_en),
        .wr_en   (pipe_en && st1_vld_reg && st1_wr_reg),
        .addr    (st1_addr_reg),
        .wr_data (st1_depth_reg),
        .rd_data (bg_rd)
    );

    dtm_level_pipe u_level (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (pipe_en),
        .st2     (st2),
        .bg      (bg_rd),
        .gain    (depth_gain_reg),
        .res_vld (res_vld),
        .res     (res)
    );

    dtm_out_skid u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_vld  (res_vld),
        .res      (res),
        .pipe_en  (pipe_en),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTHESIS
    a_frame_end_sets_bg: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready && s_tlast) |=> bg_valid_reg)
        else $error("frame end did not mark the background as taken");

    a_stored_not_live: assert property (@(posedge clk) disable iff (!rst_n)
        (st1_vld_reg && st1_wr_reg) |-> !st1_live_reg)
        else $error("stored pixel marked for scoring");
`endif

endmodule

FILE: verif/depth_touch_map_tb.sv
`timescale 1ns / 1ps

module depth_touch_map_tb;
    import dtm_pkg::*;

    typedef struct {
        logic [9:0]  x;
        logic [8:0]  y;
        logic [15:0] depth;
        logic        mode;
        logic        last;
    } pixel_t;

    typedef struct {
        logic [9:0] x;
        logic [8:0] y;
        logic [7:0] level;
    } touch_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Register copies, starting from their reset values.
    logic [23:0] cfg_gain = 24'd65536;
    logic [9:0]  cfg_x_min = '0;
    logic [9:0]  cfg_x_max = '0;
    logic [8:0]  cfg_y_min = '0;
    logic [8:0]  cfg_y_max = '0;

    // Background frame as the predictor sees it, at acceptance.
    logic [15:0] bg_mem [int];
    bit          bg_taken = 1'b0;
    // Background frame as the stimulus plans it, ahead of the bus.
    logic [15:0] planned_bg [int];
    bit          planned_taken = 1'b0;

    pixel_t pix_queue [$];
    pixel_t bus_pix;
    touch_t level_q [$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int errors = 0;
    int n_sent = 0;
    int n_results = 0;
    int n_lit = 0;
    int n_captured = 0;

    depth_touch_map u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    function automatic bit in_window(int x, int y);
        return x >= cfg_x_min && x <= cfg_x_max && y >= cfg_y_min && y <= cfg_y_max;
    endfunction

    // Background minus depth, scaled by the gain, saturated at 1.0, cubed and
    // mapped onto 0..255.
    function automatic logic [7:0] touch_level_of(logic [15:0] bg, logic [15:0] d,
                                                  logic [23:0] gain);
        longint unsigned scaled;
        longint unsigned cube;
        longint unsigned lvl;
        if (d == 16'd0 || bg <= d)
            return 8'd0;
        scaled = (longint'(bg - d) * longint'(gain)) >> 16;
        if (scaled > 64'd65536)
            scaled = 64'd65536;
        cube = scaled * scaled * scaled;
        lvl = (cube * 64'd255) >> 48;
        if (lvl > 64'd255)
            lvl = 64'd255;
        return lvl[7:0];
    endfunction

    function automatic void predict_pixel(input pixel_t p);
        int          idx;
        logic [7:0]  lvl;
        touch_t      t;
        lvl = 8'd0;
        if (p.x < FRAME_WIDTH && p.y < FRAME_HEIGHT) begin
            idx = int'(p.y) * FRAME_WIDTH + int'(p.x);
            // The store is written before it is read, so a captured pixel
            // is compared with itself.
            if (p.mode || !bg_taken) begin
                bg_mem[idx] = p.depth;
                n_captured++;
            end
            if (in_window(p.x, p.y))
                lvl = touch_level_of(bg_mem.exists(idx) ? bg_mem[idx] : 16'd0,
                                     p.depth, cfg_gain);
        end
        if (p.last)
            bg_taken = 1'b1;
        t.x = p.x;
        t.y = p.y;
        t.level = lvl;
        level_q.insert(level_q.size(), t);
    endfunction

    task automatic queue_pixel(input int x, input int y, input logic [15:0] d,
                               input logic m, input logic l);
        pixel_t p;
        p.x = x[9:0];
        p.y = y[8:0];
        p.depth = d;
        p.mode = m;
        p.last = l;
        if (x < FRAME_WIDTH && y < FRAME_HEIGHT && (m || !planned_taken))
            planned_bg[y * FRAME_WIDTH + x] = d;
        if (l)
            planned_taken = 1'b1;
        pix_queue.insert(pix_queue.size(), p);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [23:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_DEPTH_GAIN:   cfg_gain  = val;
            REG_WINDOW_X_MIN: cfg_x_min = val[9:0];
            REG_WINDOW_X_MAX: cfg_x_max = val[9:0];
            REG_WINDOW_Y_MIN: cfg_y_min = val[8:0];
            REG_WINDOW_Y_MAX: cfg_y_max = val[8:0];
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(input logic [23:0] gain, input int x0, input int x1,
                              input int y0, input int y1);
        write_reg(REG_DEPTH_GAIN, gain);
        write_reg(REG_WINDOW_X_MIN, 24'(x0));
        write_reg(REG_WINDOW_X_MAX, 24'(x1));
        write_reg(REG_WINDOW_Y_MIN, 24'(y0));
        write_reg(REG_WINDOW_Y_MAX, 24'(y1));
    endtask

    task automatic wait_drained();
        while (pix_queue.size() != 0 || s_tvalid || level_q.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    // Pixels at background points inside the window carry most of the load; a
    // non-captured pixel inside the window only ever lands on a stored point.
    task automatic gen_phase(input int n);
        int          pool [$];
        int          kind;
        int          idx;
        int          x;
        int          y;
        int          tries;
        logic [15:0] d;
        logic [15:0] bg;
        logic [15:0] delta;
        bit          open_win;
        open_win = cfg_x_min <= cfg_x_max && cfg_y_min <= cfg_y_max;
        foreach (planned_bg[k])
            if (in_window(k % FRAME_WIDTH, k / FRAME_WIDTH))
                pool.insert(pool.size(), k);
        repeat (n) begin
            kind = $urandom_range(0, 99);
            if (kind < 60 && pool.size() != 0) begin
                idx = pool[$urandom_range(0, pool.size() - 1)];
                bg = planned_bg[idx];
                case ($urandom_range(0, 9))
                    0: d = 16'd0;
                    1: d = 16'($urandom);
                    default:
                    begin
                        delta = 16'($urandom_range(0, 65535) >> $urandom_range(0, 15));
                        d = (bg > delta) ? bg - delta : 16'd1;
                    end
                endcase
                queue_pixel(idx % FRAME_WIDTH, idx / FRAME_WIDTH, d, 1'b0,
                            $urandom_range(0, 15) == 0);
            end else if (kind < 80 && open_win) begin
                x = $urandom_range(cfg_x_min, cfg_x_max);
                y = $urandom_range(cfg_y_min, cfg_y_max);
                d = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                 : 16'($urandom_range(32768, 65535));
                queue_pixel(x, y, d, 1'b1, $urandom_range(0, 15) == 0);
                pool.insert(pool.size(), y * FRAME_WIDTH + x);
            end else if (kind < 92) begin
                tries = 0;
                do begin
                    x = $urandom_range(0, FRAME_WIDTH - 1);
                    y = $urandom_range(0, FRAME_HEIGHT - 1);
                    tries++;
                end while (in_window(x, y) && tries < 16);
                if (in_window(x, y)) begin
                    x = $urandom_range(FRAME_WIDTH, 1023);
                    y = $urandom_range(0, 511);
                end
                queue_pixel(x, y, 16'($urandom), $urandom_range(0, 1),
                            $urandom_range(0, 15) == 0);
            end else if (kind < 96) begin
                if ($urandom_range(0, 1)) begin
                    x = $urandom_range(FRAME_WIDTH, 1023);
                    y = $urandom_range(0, 511);
                end else begin
                    x = $urandom_range(0, 1023);
                    y = $urandom_range(FRAME_HEIGHT, 511);
                end
                queue_pixel(x, y, 16'($urandom), $urandom_range(0, 1),
                            $urandom_range(0, 15) == 0);
            end else begin
                x = $urandom_range(0, FRAME_WIDTH - 1);
                y = $urandom_range(0, FRAME_HEIGHT - 1);
                queue_pixel(x, y, 16'($urandom), 1'b1, $urandom_range(0, 15) == 0);
                if (in_window(x, y))
                    pool.insert(pool.size(), y * FRAME_WIDTH + x);
            end
        end
    endtask

    initial begin
        forever #1 clk = ~clk;
    end

    // Pixel driver: predicts each pixel as its transfer completes.
    always @(posedge clk) begin
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                predict_pixel(bus_pix);
                n_sent++;
            end
            if (!s_tvalid || s_tready) begin
                if (pix_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    bus_pix = pix_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {5'b0, bus_pix.depth, bus_pix.y, bus_pix.x};
                    s_tuser  <= bus_pix.mode;
                    s_tlast  <= bus_pix.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor.
    always @(posedge clk) begin
        touch_t want;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (m_tdata[26:19] != 8'd0)
                    n_lit++;
                if (level_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with nothing expected: x %0d y %0d level %0d",
                             $time, m_tdata[9:0], m_tdata[18:10], m_tdata[26:19]);
                end else begin
                    want = level_q.pop_front();
                    if (m_tdata[9:0] != want.x) begin
                        errors++;
                        $display("%0t: out_x mismatch, expected %0d, got %0d",
                                 $time, want.x, m_tdata[9:0]);
                    end
                    if (m_tdata[18:10] != want.y) begin
                        errors++;
                        $display("%0t: out_y mismatch, expected %0d, got %0d",
                                 $time, want.y, m_tdata[18:10]);
                    end
                    if (m_tdata[26:19] !== want.level) begin
                        errors++;
                        $display("%0t: touch_level mismatch at (%0d,%0d), expected %0d, got %0d",
                                 $time, want.x, want.y, want.level, m_tdata[26:19]);
                    end
                end
            end
            m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    initial begin
        #2_000_000;
        $display("depth_touch_map_tb: FAIL");
        $finish;
    end

    initial begin
        int          p;
        logic [23:0] g;
        int          xa;
        int          xb;
        int          ya;
        int          yb;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        send_idle_pct = 33;
        recv_idle_pct = 62;

        // First frame under the reset registers: every in-frame pixel is stored, and the
        // one pixel inside the default window meets its own background.
        queue_pixel(0, 0, 16'd60000, 1'b0, 1'b0);
        queue_pixel(639, 479, 16'd65535, 1'b0, 1'b0);
        queue_pixel(1, 0, 16'd40000, 1'b1, 1'b0);
        queue_pixel(320, 240, 16'd50000, 1'b0, 1'b0);
        queue_pixel(512, 256, 16'd30000, 1'b0, 1'b0);
        queue_pixel(100, 100, 16'd0, 1'b0, 1'b0);
        queue_pixel(700, 10, 16'd1234, 1'b0, 1'b0);
        queue_pixel(5, 500, 16'd1234, 1'b0, 1'b0);
        queue_pixel(383, 127, 16'd45000, 1'b0, 1'b1);
        wait_drained();

        set_config(24'd65536, 0, FRAME_WIDTH - 1, 0, FRAME_HEIGHT - 1);
        queue_pixel(0, 0, 16'd10000, 1'b0, 1'b0);
        queue_pixel(639, 479, 16'd0, 1'b0, 1'b0);
        queue_pixel(639, 479, 16'd65535, 1'b0, 1'b0);
        queue_pixel(320, 240, 16'd60000, 1'b0, 1'b0);
        queue_pixel(512, 256, 16'd1, 1'b0, 1'b0);
        queue_pixel(1, 0, 16'd0, 1'b0, 1'b0);
        queue_pixel(100, 100, 16'd5, 1'b0, 1'b0);
        queue_pixel(383, 127, 16'd40000, 1'b1, 1'b0);
        queue_pixel(383, 127, 16'd100, 1'b0, 1'b0);
        queue_pixel(1023, 511, 16'd7, 1'b1, 1'b1);
        queue_pixel(320, 240, 16'd1, 1'b0, 1'b0);
        wait_drained();

        for (p = 0; p < 9; p++) begin
            if (p < 3) begin
                send_idle_pct = 33;
                recv_idle_pct = 62;
            end else if (p < 6) begin
                send_idle_pct = 62;
                recv_idle_pct = 33;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            xa = $urandom_range(0, FRAME_WIDTH - 1);
            xb = $urandom_range(0, FRAME_WIDTH - 1);
            ya = $urandom_range(0, FRAME_HEIGHT - 1);
            yb = $urandom_range(0, FRAME_HEIGHT - 1);
            if (xa > xb) begin
                xa = xa ^ xb;
                xb = xa ^ xb;
                xa = xa ^ xb;
            end
            if (ya > yb) begin
                ya = ya ^ yb;
                yb = ya ^ yb;
                ya = ya ^ yb;
            end
            case (p)
                0: set_config(24'd0, 0, FRAME_WIDTH - 1, 0, FRAME_HEIGHT - 1);
                1: set_config(24'hFFFFFF, 0, FRAME_WIDTH - 1, 0, FRAME_HEIGHT - 1);
                2: set_config(24'd65536, xa, xb, ya, yb);
                // Empty window: minimum column above maximum.
                3: set_config(24'($urandom_range(0, 24'h3FFFF)), FRAME_WIDTH - 1, 0,
                              0, FRAME_HEIGHT - 1);
                4: set_config(24'($urandom_range(20000, 200000)), FRAME_WIDTH - 1,
                              FRAME_WIDTH - 1, 0, FRAME_HEIGHT - 1);
                5: set_config(24'd131072, xa, xb, ya, yb);
                6: set_config(24'($urandom), xa, xb, ya, yb);
                7: set_config(24'd65536, 0, FRAME_WIDTH - 1, 0, FRAME_HEIGHT - 1);
                default:
                begin
                    g = 24'($urandom_range(40000, 300000));
                    set_config(g, xa, xb, ya, yb);
                end
            endcase
            gen_phase(138);
            wait_drained();
        end

        $display("Ran %0d pixels through nine register settings; %0d results checked,",
                 n_sent, n_results);
        $display("%0d with a non-zero touch level, %0d background writes, %0d errors.",
                 n_lit, n_captured, errors);
        if (errors == 0 && level_q.size() == 0)
            $display("depth_touch_map_tb: PASS");
        else
            $display("depth_touch_map_tb: FAIL");
        $finish;
    end

endmodule

FILE: filelist.f
sv/dtm_pkg.sv
sv/dtm_frame_store.sv
sv/dtm_level_pipe.sv
sv/dtm_out_skid.sv
sv/depth_touch_map.sv
verif/depth_touch_map_tb.sv
